// File: rtl/core/xmodem_block_receiver_unit_macros.svh
// assertion macros for the xmodem block receiver unit
// no dependencies; included by files that carry concurrent checks
`ifndef XMODEM_BLOCK_RECEIVER_UNIT_MACROS_SVH
`define XMODEM_BLOCK_RECEIVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define XBR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xmodem receiver check failed");
// next-cycle implication, sampled on clk, off during reset
`define XBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xmodem receiver check failed");
`else
`define XBR_ASSERT_NOW(lbl, ante, cons)
`define XBR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/xbr_pkg.sv
// shared types, protocol characters and crc helper for the xmodem receiver
// no dependencies
`timescale 1ns / 1ps

package xbr_pkg;

    // default data bytes per block
    localparam int XBR_BLOCK_BYTES = 128;

    // item opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_CRC_MODE      = 8'd0;
    localparam logic [7:0] CFG_LINE_FEED     = 8'd1;
    localparam logic [7:0] CFG_START_TIMEOUT = 8'd2;
    localparam logic [7:0] CFG_BYTE_TIMEOUT  = 8'd3;

    // line characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_SUB = 8'h1A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

    // verdict codes
    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [1:0] VERDICT_REJECT = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_IDLE      = 2'd0;
    localparam logic [1:0] STATUS_RECEIVING = 2'd1;
    localparam logic [1:0] STATUS_COMPLETE  = 2'd2;
    localparam logic [1:0] STATUS_CANCELLED = 2'd3;

    // receiver phases, one-hot
    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_SOH    = 10'b00_0000_0010,
        PH_NUM    = 10'b00_0000_0100,
        PH_COMP   = 10'b00_0000_1000,
        PH_DATA   = 10'b00_0001_0000,
        PH_CHI    = 10'b00_0010_0000,
        PH_CLO    = 10'b00_0100_0000,
        PH_PURGE  = 10'b00_1000_0000,
        PH_DONE   = 10'b01_0000_0000,
        PH_CANCEL = 10'b10_0000_0000
    } phase_t;

    // input item
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } xbr_in_t;

    // result item
    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [1:0] verdict;
        logic [7:0] block_number;
        logic [1:0] status;
    } xbr_out_t;

    // crc-16/xmodem over one byte, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/core/xmodem_block_receiver_unit.sv
// xmodem block receiver: framing, crc/sum check, replies and data delivery
// depends on xbr_pkg and xmodem_block_receiver_unit_macros.svh
`timescale 1ns / 1ps
`include "xmodem_block_receiver_unit_macros.svh"

// channel  | handshake            | payload
// ---------+----------------------+------------------------------------
// in       | in_valid / in_ready  | in_data   (opcode, rx_byte)
// out      | out_valid/ out_ready | out_data  (reply, data, verdict, ...)
// cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// one item per cycle: the state update and the crc byte step sit between the
// accepted item and the result register, so the result appears in the next cycle.
// a full result register stalls input only while out_ready is low.
// reset (rst_n, async) sets config to its defaults and the receiver idle.
// cfg_ready is always high; writes to unknown indexes are dropped.

module xmodem_block_receiver_unit
    import xbr_pkg::*;
#(
    parameter int BLOCK_BYTES = XBR_BLOCK_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  xbr_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output xbr_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(BLOCK_BYTES);

    // configuration
    logic        crc_mode_reg;
    logic        line_feed_mode_reg;
    logic [15:0] start_timeout_reg;
    logic [15:0] byte_timeout_reg;

    // receiver state
    phase_t           phase_reg, phase_next;
    logic [7:0]       expected_block_reg, expected_block_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      crc_acc_reg, crc_acc_next;
    logic [7:0]       sum_acc_reg, sum_acc_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic [15:0]      silence_reg, silence_next;
    logic [7:0]       pending_reply_reg, pending_reply_next;
    logic             eot_seen_reg, eot_seen_next;

    // result register
    logic     out_valid_reg;
    xbr_out_t out_data_reg;
    xbr_out_t result;

    logic        in_accept;
    logic        active;
    logic [7:0]  start_code;
    logic [15:0] silence_inc;
    logic [15:0] limit;
    logic        check_ok;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    assign active = !(phase_reg == PH_IDLE || phase_reg == PH_DONE
                      || phase_reg == PH_CANCEL);
    assign start_code  = crc_mode_reg ? CH_C : CH_NAK;
    assign silence_inc = (silence_reg == SILENCE_MAX) ? silence_reg
                                                      : silence_reg + 16'd1;
    assign limit    = (phase_reg == PH_SOH) ? start_timeout_reg : byte_timeout_reg;
    assign check_ok = crc_mode_reg ? ({crc_high_reg, in_data.rx_byte} == crc_acc_reg)
                                   : (in_data.rx_byte == sum_acc_reg);

    // next state and result of one item
    always_comb
    begin
        phase_next          = phase_reg;
        expected_block_next = expected_block_reg;
        byte_index_next     = byte_index_reg;
        crc_acc_next        = crc_acc_reg;
        sum_acc_next        = sum_acc_reg;
        crc_high_next       = crc_high_reg;
        silence_next        = silence_reg;
        pending_reply_next  = pending_reply_reg;
        eot_seen_next       = eot_seen_reg;
        result              = '0;

        unique case (in_data.opcode)
            OP_START:
            begin
                expected_block_next = 8'd1;
                byte_index_next     = '0;
                crc_acc_next        = '0;
                sum_acc_next        = '0;
                crc_high_next       = '0;
                silence_next        = '0;
                pending_reply_next  = '0;
                eot_seen_next       = 1'b0;
                phase_next          = PH_SOH;
                result.reply_valid  = 1'b1;
                result.reply_byte   = start_code;
            end
            OP_BYTE:
            begin
                if (active)
                begin
                    silence_next = '0;
                    unique case (phase_reg)
                        PH_SOH:
                        begin
                            if (in_data.rx_byte == CH_EOT)
                            begin
                                result.reply_valid = 1'b1;
                                result.reply_byte  = CH_ACK;
                                phase_next         = PH_DONE;
                            end
                            else if (in_data.rx_byte == CH_CAN)
                                phase_next = PH_CANCEL;
                            else if (in_data.rx_byte == CH_SOH)
                                phase_next = PH_NUM;
                            else
                            begin
                                phase_next         = PH_PURGE;
                                pending_reply_next = CH_NAK;
                            end
                        end
                        PH_NUM:
                        begin
                            if (in_data.rx_byte == expected_block_reg)
                                phase_next = PH_COMP;
                            else
                            begin
                                phase_next         = PH_PURGE;
                                pending_reply_next = CH_NAK;
                            end
                        end
                        PH_COMP:
                        begin
                            if (in_data.rx_byte == ~expected_block_reg)
                            begin
                                phase_next      = PH_DATA;
                                byte_index_next = '0;
                                crc_acc_next    = '0;
                                sum_acc_next    = '0;
                                crc_high_next   = '0;
                                eot_seen_next   = 1'b0;
                            end
                            else
                            begin
                                phase_next         = PH_PURGE;
                                pending_reply_next = CH_NAK;
                            end
                        end
                        PH_DATA:
                        begin
                            crc_acc_next = crc16_update(crc_acc_reg, in_data.rx_byte);
                            sum_acc_next = sum_acc_reg + in_data.rx_byte;
                            // text mode drops cr and everything from the first sub
                            if (line_feed_mode_reg)
                            begin
                                eot_seen_next = eot_seen_reg || (in_data.rx_byte == CH_SUB);
                                if (!eot_seen_next && in_data.rx_byte != CH_CR)
                                begin
                                    result.data_valid = 1'b1;
                                    result.data_byte  = in_data.rx_byte;
                                end
                            end
                            else
                            begin
                                result.data_valid = 1'b1;
                                result.data_byte  = in_data.rx_byte;
                            end
                            byte_index_next = byte_index_reg + 1'b1;
                            if (byte_index_reg == IDX_W'(BLOCK_BYTES - 1))
                                phase_next = crc_mode_reg ? PH_CHI : PH_CLO;
                        end
                        PH_CHI:
                        begin
                            crc_high_next = in_data.rx_byte;
                            phase_next    = PH_CLO;
                        end
                        PH_CLO:
                        begin
                            if (check_ok)
                            begin
                                result.reply_valid  = 1'b1;
                                result.reply_byte   = CH_ACK;
                                result.verdict      = VERDICT_ACCEPT;
                                expected_block_next = expected_block_reg + 8'd1;
                                phase_next          = PH_SOH;
                            end
                            else
                            begin
                                result.verdict     = VERDICT_REJECT;
                                phase_next         = PH_PURGE;
                                pending_reply_next = CH_NAK;
                            end
                        end
                        default:
                        begin
                            // purge: byte only restarts the quiet time
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (active)
                begin
                    silence_next = silence_inc;
                    if (silence_inc >= limit)
                    begin
                        if (phase_reg == PH_SOH)
                        begin
                            phase_next         = PH_PURGE;
                            pending_reply_next = start_code;
                            silence_next       = '0;
                        end
                        else if (phase_reg == PH_PURGE)
                        begin
                            result.reply_valid = 1'b1;
                            result.reply_byte  = pending_reply_reg;
                            phase_next         = PH_SOH;
                            silence_next       = '0;
                        end
                        else
                        begin
                            // timeout once data began rejects the block
                            if (phase_reg == PH_DATA || phase_reg == PH_CHI
                                || phase_reg == PH_CLO)
                                result.verdict = VERDICT_REJECT;
                            phase_next         = PH_PURGE;
                            pending_reply_next = CH_NAK;
                            silence_next       = '0;
                        end
                    end
                end
            end
            default:
            begin
                // unused opcode: result only
            end
        endcase

        // purge entry always restarts the quiet time
        if (phase_next == PH_PURGE && phase_reg != PH_PURGE)
            silence_next = '0;

        result.block_number = expected_block_next;
        unique case (phase_next)
            PH_IDLE:   result.status = STATUS_IDLE;
            PH_DONE:   result.status = STATUS_COMPLETE;
            PH_CANCEL: result.status = STATUS_CANCELLED;
            default:   result.status = STATUS_RECEIVING;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_mode_reg       <= 1'b1;
            line_feed_mode_reg <= 1'b0;
            start_timeout_reg  <= 16'd10;
            byte_timeout_reg   <= 16'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CRC_MODE:      crc_mode_reg       <= cfg_data[0];
                CFG_LINE_FEED:     line_feed_mode_reg <= cfg_data[0];
                CFG_START_TIMEOUT: start_timeout_reg  <= cfg_data;
                CFG_BYTE_TIMEOUT:  byte_timeout_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // receiver state, updated per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            expected_block_reg <= 8'd1;
            byte_index_reg     <= '0;
            crc_acc_reg        <= '0;
            sum_acc_reg        <= '0;
            crc_high_reg       <= '0;
            silence_reg        <= '0;
            pending_reply_reg  <= '0;
            eot_seen_reg       <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg          <= phase_next;
            expected_block_reg <= expected_block_next;
            byte_index_reg     <= byte_index_next;
            crc_acc_reg        <= crc_acc_next;
            sum_acc_reg        <= sum_acc_next;
            crc_high_reg       <= crc_high_next;
            silence_reg        <= silence_next;
            pending_reply_reg  <= pending_reply_next;
            eot_seen_reg       <= eot_seen_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= result;
    end

    // a start item always opens a transfer at block one with a reply
    `XBR_ASSERT_NEXT(a_start_opens,
        in_accept && in_data.opcode == OP_START,
        out_valid && out_data.reply_valid && out_data.block_number == 8'd1
        && out_data.status == STATUS_RECEIVING)
    // a delivered data byte never comes with a reply or a verdict
    `XBR_ASSERT_NOW(a_data_alone,
        out_valid && out_data.data_valid,
        !out_data.reply_valid && out_data.verdict == VERDICT_NONE)
    // an accepted block is always acknowledged
    `XBR_ASSERT_NOW(a_accept_acks,
        out_valid && out_data.verdict == VERDICT_ACCEPT,
        out_data.reply_valid && out_data.reply_byte == CH_ACK)
    // reply byte reads zero when no reply is sent
    `XBR_ASSERT_NOW(a_reply_clean,
        out_valid && !out_data.reply_valid,
        out_data.reply_byte == 8'd0)

endmodule

// File: sim/tb.sv
// testbench for xmodem_block_receiver_unit: directed framing, timeout and config cases,
// then random block traffic, every result checked against an in-bench receiver predictor
// depends on xbr_pkg and the receiver rtl
`timescale 1ns / 1ps

module tb;
    import xbr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_SLACK = 8;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_NUMBER,
        FLAW_COMPLEMENT,
        FLAW_DUPLICATE,
        FLAW_CHECK,
        FLAW_CUT
    } block_flaw_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    xbr_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    xbr_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // predictor copy of the configuration, at reset values
    logic        cfg_crc_mode    = 1'b1;
    logic        cfg_line_feed   = 1'b0;
    logic [15:0] cfg_start_limit = 16'd10;
    logic [15:0] cfg_byte_limit  = 16'd2;

    // predictor copy of the receiver state
    phase_t      rx_phase    = PH_IDLE;
    logic [7:0]  rx_block    = 8'd1;
    logic [15:0] rx_count    = '0;
    logic [15:0] crc_acc     = '0;
    logic [7:0]  sum_acc     = '0;
    logic [7:0]  crc_hi      = '0;
    logic [15:0] quiet_ticks = '0;
    logic [7:0]  purge_reply = '0;
    logic        sub_seen    = 1'b0;

    xbr_out_t    predicted_outputs[$];
    xbr_out_t    oldest;
    int unsigned mismatch_count = 0;
    int unsigned useful_items   = 0;
    int unsigned cycle_count    = 0;
    bit          no_idle        = 1'b0;

    xmodem_block_receiver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // crc-16/xmodem, one message bit at a time
    function automatic logic [15:0] crc_step(logic [15:0] acc, logic [7:0] value);
        logic [15:0] r;
        logic        feedback;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = r[15] ^ value[i];
            r = {r[14:0], 1'b0};
            if (feedback)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic logic [7:0] start_reply();
        return cfg_crc_mode ? CH_C : CH_NAK;
    endfunction

    function automatic void enter_purge(logic [7:0] code);
        rx_phase    = PH_PURGE;
        purge_reply = code;
        quiet_ticks = '0;
    endfunction

    // next receiver state and the result of one accepted item
    function automatic xbr_out_t step_receiver(xbr_in_t item);
        xbr_out_t    r;
        logic [15:0] limit;
        logic        active;
        logic        check_ok;
        r = '0;
        active = rx_phase inside {PH_SOH, PH_NUM, PH_COMP, PH_DATA, PH_CHI, PH_CLO, PH_PURGE};
        if (item.opcode == OP_START)
        begin
            useful_items++;
            rx_block    = 8'd1;
            rx_count    = '0;
            crc_acc     = '0;
            sum_acc     = '0;
            crc_hi      = '0;
            quiet_ticks = '0;
            purge_reply = '0;
            sub_seen    = 1'b0;
            rx_phase    = PH_SOH;
            r.reply_valid = 1'b1;
            r.reply_byte  = start_reply();
        end
        else if (item.opcode == OP_BYTE && active)
        begin
            useful_items++;
            quiet_ticks = '0;
            case (rx_phase)
                PH_SOH:
                begin
                    if (item.rx_byte == CH_EOT)
                    begin
                        r.reply_valid = 1'b1;
                        r.reply_byte  = CH_ACK;
                        rx_phase      = PH_DONE;
                    end
                    else if (item.rx_byte == CH_CAN)
                        rx_phase = PH_CANCEL;
                    else if (item.rx_byte == CH_SOH)
                        rx_phase = PH_NUM;
                    else
                        enter_purge(CH_NAK);
                end
                PH_NUM:
                begin
                    if (item.rx_byte == rx_block)
                        rx_phase = PH_COMP;
                    else
                        enter_purge(CH_NAK);
                end
                PH_COMP:
                begin
                    if (item.rx_byte == 8'(~rx_block))
                    begin
                        rx_phase = PH_DATA;
                        rx_count = '0;
                        crc_acc  = '0;
                        sum_acc  = '0;
                        crc_hi   = '0;
                        sub_seen = 1'b0;
                    end
                    else
                        enter_purge(CH_NAK);
                end
                PH_DATA:
                begin
                    crc_acc = crc_step(crc_acc, item.rx_byte);
                    sum_acc = sum_acc + item.rx_byte;
                    // line-feed mode drops cr and everything from the first sub on
                    if (cfg_line_feed)
                    begin
                        if (item.rx_byte == CH_SUB)
                            sub_seen = 1'b1;
                        if (!sub_seen && item.rx_byte != CH_CR)
                        begin
                            r.data_valid = 1'b1;
                            r.data_byte  = item.rx_byte;
                        end
                    end
                    else
                    begin
                        r.data_valid = 1'b1;
                        r.data_byte  = item.rx_byte;
                    end
                    rx_count = rx_count + 16'd1;
                    if (rx_count >= XBR_BLOCK_BYTES)
                        rx_phase = cfg_crc_mode ? PH_CHI : PH_CLO;
                end
                PH_CHI:
                begin
                    crc_hi   = item.rx_byte;
                    rx_phase = PH_CLO;
                end
                PH_CLO:
                begin
                    if (cfg_crc_mode)
                        check_ok = ({crc_hi, item.rx_byte} == crc_acc);
                    else
                        check_ok = (item.rx_byte == sum_acc);
                    if (check_ok)
                    begin
                        r.reply_valid = 1'b1;
                        r.reply_byte  = CH_ACK;
                        r.verdict     = VERDICT_ACCEPT;
                        rx_block      = rx_block + 8'd1;
                        rx_phase      = PH_SOH;
                    end
                    else
                    begin
                        r.verdict = VERDICT_REJECT;
                        enter_purge(CH_NAK);
                    end
                end
                default: ;
            endcase
        end
        else if (item.opcode == OP_TICK && active)
        begin
            useful_items++;
            limit = (rx_phase == PH_SOH) ? cfg_start_limit : cfg_byte_limit;
            if (quiet_ticks != SILENCE_MAX)
                quiet_ticks = quiet_ticks + 16'd1;
            if (quiet_ticks >= limit)
            begin
                if (rx_phase == PH_SOH)
                    enter_purge(start_reply());
                else if (rx_phase == PH_PURGE)
                begin
                    r.reply_valid = 1'b1;
                    r.reply_byte  = purge_reply;
                    rx_phase      = PH_SOH;
                    quiet_ticks   = '0;
                end
                else
                begin
                    if (rx_phase inside {PH_DATA, PH_CHI, PH_CLO})
                        r.verdict = VERDICT_REJECT;
                    enter_purge(CH_NAK);
                end
            end
        end
        r.block_number = rx_block;
        case (rx_phase)
            PH_IDLE:   r.status = STATUS_IDLE;
            PH_DONE:   r.status = STATUS_COMPLETE;
            PH_CANCEL: r.status = STATUS_CANCELLED;
            default:   r.status = STATUS_RECEIVING;
        endcase
        return r;
    endfunction

    // send one item, with random gaps ahead of it
    task automatic offer_item(logic [1:0] op, logic [7:0] value);
        xbr_in_t item;
        item.opcode  = op;
        item.rx_byte = value;
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_outputs.push_back(step_receiver(item));
    endtask

    // hold the input and let every predicted result come out
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(logic [7:0] idx, logic [15:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CRC_MODE:      cfg_crc_mode    = value[0];
            CFG_LINE_FEED:     cfg_line_feed   = value[0];
            CFG_START_TIMEOUT: cfg_start_limit = value;
            CFG_BYTE_TIMEOUT:  cfg_byte_limit  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic crc, logic lf, logic [15:0] start_ticks,
                              logic [15:0] byte_ticks);
        write_register(CFG_CRC_MODE, {15'd0, crc});
        write_register(CFG_LINE_FEED, {15'd0, lf});
        write_register(CFG_START_TIMEOUT, start_ticks);
        write_register(CFG_BYTE_TIMEOUT, byte_ticks);
    endtask

    // bring the receiver back to waiting for a block header
    task automatic settle_to_soh();
        while (rx_phase != PH_SOH)
        begin
            if (rx_phase inside {PH_IDLE, PH_DONE, PH_CANCEL} || cfg_byte_limit > 16)
                offer_item(OP_START, 8'($urandom));
            else
                offer_item(OP_TICK, 8'($urandom));
        end
    endtask

    // one block for the expected number, optionally damaged
    task automatic send_block(block_flaw_t flaw);
        logic [7:0]  payload [XBR_BLOCK_BYTES];
        logic [7:0]  number;
        logic [15:0] crc;
        logic [7:0]  sum;
        int unsigned cut;
        int unsigned pick;
        number = (flaw == FLAW_DUPLICATE) ? rx_block - 8'd1 : rx_block;
        crc = '0;
        sum = '0;
        // random data with cr and sub mixed in
        for (int i = 0; i < XBR_BLOCK_BYTES; i++)
        begin
            pick = $urandom_range(15);
            if (pick == 0)
                payload[i] = CH_CR;
            else if (pick == 1)
                payload[i] = CH_SUB;
            else
                payload[i] = 8'($urandom);
            crc = crc_step(crc, payload[i]);
            sum = sum + payload[i];
        end
        cut = (flaw == FLAW_CUT) ? $urandom_range(XBR_BLOCK_BYTES - 1) : XBR_BLOCK_BYTES;
        offer_item(OP_BYTE, CH_SOH);
        offer_item(OP_BYTE, (flaw == FLAW_NUMBER) ?
                   number ^ 8'($urandom_range(255, 1)) : number);
        offer_item(OP_BYTE, (flaw == FLAW_COMPLEMENT) ?
                   8'(~number) ^ 8'($urandom_range(255, 1)) : 8'(~number));
        for (int i = 0; i < cut; i++)
            offer_item(OP_BYTE, payload[i]);
        if (flaw == FLAW_CUT)
            return;
        if (flaw == FLAW_CHECK)
        begin
            crc = crc ^ 16'($urandom_range(65535, 1));
            sum = sum ^ 8'($urandom_range(255, 1));
        end
        if (cfg_crc_mode)
        begin
            offer_item(OP_BYTE, crc[15:8]);
            offer_item(OP_BYTE, crc[7:0]);
        end
        else
            offer_item(OP_BYTE, sum);
    endtask

    // mostly well-formed blocks, with damaged blocks, ticks, eot, can and noise
    task automatic run_traffic(int unsigned amount);
        int unsigned goal;
        int unsigned pick;
        int unsigned noise;
        goal = useful_items + amount;
        while (useful_items < goal)
        begin
            pick = $urandom_range(99);
            if (rx_phase inside {PH_IDLE, PH_DONE, PH_CANCEL})
            begin
                repeat ($urandom_range(2))
                    offer_item($urandom_range(1) ? OP_BYTE : OP_TICK, 8'($urandom));
                offer_item(OP_START, 8'($urandom));
            end
            else if (pick < 55)
            begin
                settle_to_soh();
                send_block(FLAW_NONE);
            end
            else if (pick < 70)
            begin
                settle_to_soh();
                send_block(block_flaw_t'($urandom_range(FLAW_CUT, FLAW_NUMBER)));
                settle_to_soh();
            end
            else if (pick < 78)
                repeat ($urandom_range(12, 1))
                    offer_item(OP_TICK, 8'($urandom));
            else if (pick < 81)
            begin
                settle_to_soh();
                offer_item(OP_BYTE, CH_EOT);
            end
            else if (pick < 83)
            begin
                settle_to_soh();
                offer_item(OP_BYTE, CH_CAN);
            end
            else if (pick < 85)
                offer_item(OP_START, 8'($urandom));
            else
                repeat ($urandom_range(6, 1))
                begin
                    noise = $urandom_range(9);
                    if (noise == 0)
                        offer_item(OP_START, 8'($urandom));
                    else if (noise < 5)
                        offer_item(OP_BYTE, 8'($urandom));
                    else if (noise < 8)
                        offer_item(OP_TICK, 8'($urandom));
                    else
                        offer_item(OP_UNUSED, 8'($urandom));
                end
        end
    endtask

    // bytes, ticks and the unused opcode before any transfer
    task automatic test_idle_inputs();
        offer_item(OP_BYTE, CH_SOH);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_UNUSED, 8'hFF);
    endtask

    // start, restart, eot and can, with ignored items after the end
    task automatic test_start_and_end();
        offer_item(OP_START, 8'h00);
        offer_item(OP_BYTE, CH_EOT);
        offer_item(OP_BYTE, CH_SOH);
        offer_item(OP_START, 8'hFF);
        offer_item(OP_START, 8'h00);
        offer_item(OP_BYTE, CH_CAN);
        offer_item(OP_TICK, 8'h00);
    endtask

    // stray lead byte, wrong number, wrong complement, data timeout
    task automatic test_framing_errors();
        offer_item(OP_START, 8'h00);
        offer_item(OP_BYTE, 8'h55);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_BYTE, CH_SOH);
        offer_item(OP_BYTE, 8'h02);
        offer_item(OP_UNUSED, 8'hAA);
        offer_item(OP_TICK, 8'h00);
        // a byte during the purge restarts the quiet count
        offer_item(OP_BYTE, 8'hFF);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_BYTE, CH_SOH);
        offer_item(OP_BYTE, 8'h01);
        offer_item(OP_BYTE, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_BYTE, CH_SOH);
        offer_item(OP_BYTE, 8'h01);
        offer_item(OP_BYTE, 8'hFE);
        offer_item(OP_BYTE, 8'h00);
        offer_item(OP_BYTE, 8'hFF);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
    endtask

    // shortest and longest timeouts, both start replies, unknown register index
    task automatic test_timeouts();
        set_config(1'b1, 1'b0, 16'd1, 16'd1);
        offer_item(OP_START, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
        set_config(1'b0, 1'b0, 16'd1, 16'd1);
        offer_item(OP_START, 8'h00);
        offer_item(OP_TICK, 8'h00);
        offer_item(OP_TICK, 8'h00);
        set_config(1'b1, 1'b0, 16'hFFFF, 16'hFFFF);
        offer_item(OP_START, 8'h00);
        repeat (4) offer_item(OP_TICK, 8'h00);
        offer_item(OP_BYTE, CH_SOH);
        repeat (3) offer_item(OP_TICK, 8'h00);
        write_register(8'hFF, 16'h0001);
        offer_item(OP_START, 8'h00);
    endtask

    // random block traffic across several settings
    task automatic test_random_traffic();
        set_config(1'b1, 1'b0, 16'd10, 16'd2);
        run_traffic(400);
        set_config(1'b0, 1'b1, 16'd3, 16'd1);
        no_idle = 1'b1;
        run_traffic(400);
        no_idle = 1'b0;
        set_config(1'b1, 1'b1, 16'd1, 16'd3);
        run_traffic(400);
        set_config(1'b0, 1'b0, 16'($urandom_range(12, 2)), 16'($urandom_range(4, 1)));
        run_traffic(300);
        set_config(1'b1, 1'b0, 16'hFFFF, 16'hFFFF);
        run_traffic(150);
    endtask

    // result side stalls
    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 34);

    // compare each result with the oldest prediction
    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                $display("%0t: result expected none, got %0h", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                oldest = predicted_outputs.pop_front();
                compare_field("reply_valid", 16'(oldest.reply_valid),
                              16'(out_data.reply_valid));
                compare_field("reply_byte", 16'(oldest.reply_byte),
                              16'(out_data.reply_byte));
                compare_field("data_valid", 16'(oldest.data_valid),
                              16'(out_data.data_valid));
                compare_field("data_byte", 16'(oldest.data_byte),
                              16'(out_data.data_byte));
                compare_field("verdict", 16'(oldest.verdict), 16'(out_data.verdict));
                compare_field("block_number", 16'(oldest.block_number),
                              16'(out_data.block_number));
                compare_field("status", 16'(oldest.status), 16'(out_data.status));
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[xmodem_block_receiver_unit] ERROR");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_inputs();
        test_start_and_end();
        test_framing_errors();
        test_timeouts();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatch_count == 0 && predicted_outputs.size() == 0)
            $display("[xmodem_block_receiver_unit] OK");
        else
            $display("[xmodem_block_receiver_unit] ERROR");
        $finish;
    end

endmodule
